// ===== rtl/hts_pkg.sv =====
// ----------------------------------------------------------------------------
// hts_pkg
// Types, constants and jamo tables for the two-set Hangul composer.
// ----------------------------------------------------------------------------
`default_nettype none

package hts_pkg;

  // Key classes carried on the input tuser
  typedef enum logic [2:0] {
    MODE_CONS    = 3'd0,
    MODE_VOWEL   = 3'd1,
    MODE_BKSP    = 3'd2,
    MODE_SPACE   = 3'd3,
    MODE_NEWLINE = 3'd4,
    MODE_OTHER   = 3'd5
  } hts_mode_e;

  localparam logic [15:0] SYL_BASE       = 16'hAC00;
  localparam logic [15:0] SYL_INIT_STEP  = 16'd588;
  localparam logic [15:0] SYL_MED_STEP   = 16'd28;
  localparam logic [15:0] VOWEL_BASE     = 16'h314F;
  localparam logic [15:0] CODE_SPACE     = 16'h0020;
  localparam logic [15:0] CODE_NEWLINE   = 16'h000A;
  localparam logic [4:0]  NUM_INITIALS   = 5'd19;
  localparam logic [4:0]  NUM_VOWELS     = 5'd21;
  localparam logic [4:0]  NO_FINAL       = 5'd0;

  // Result plan for one key, passed from the front to the back
  typedef struct packed {
    logic [1:0]  n_commit;
    logic [15:0] commit0;
    logic [15:0] commit1;
    logic        erase;
    logic        pre_valid;
    logic [15:0] pre_char;
  } hts_plan_t;

  // Composition state
  typedef struct packed {
    logic       ini_present;
    logic [4:0] ini_jamo;
    logic       med_present;
    logic [4:0] med_jamo;
    logic [4:0] fin_jamo;
  } hts_comp_t;

  // Merged medial with a hit flag
  typedef struct packed {
    logic       hit;
    logic [4:0] jamo;
  } hts_merge_t;

  function automatic logic [15:0] initial_code(input logic [4:0] i);
    logic [15:0] code;
    unique case (i)
      5'd0:    code = 16'h3131;
      5'd1:    code = 16'h3132;
      5'd2:    code = 16'h3134;
      5'd3:    code = 16'h3137;
      5'd4:    code = 16'h3138;
      5'd5:    code = 16'h3139;
      5'd6:    code = 16'h3141;
      5'd7:    code = 16'h3142;
      5'd8:    code = 16'h3143;
      5'd9:    code = 16'h3145;
      5'd10:   code = 16'h3146;
      5'd11:   code = 16'h3147;
      5'd12:   code = 16'h3148;
      5'd13:   code = 16'h3149;
      5'd14:   code = 16'h314A;
      5'd15:   code = 16'h314B;
      5'd16:   code = 16'h314C;
      5'd17:   code = 16'h314D;
      5'd18:   code = 16'h314E;
      default: code = 16'h3131;
    endcase
    return code;
  endfunction

  // Initial index to final index; zero where it cannot close a syllable
  function automatic logic [4:0] initial_to_final(input logic [4:0] c);
    logic [4:0] f;
    unique case (c)
      5'd0:    f = 5'd1;
      5'd1:    f = 5'd2;
      5'd2:    f = 5'd4;
      5'd3:    f = 5'd7;
      5'd5:    f = 5'd8;
      5'd6:    f = 5'd16;
      5'd7:    f = 5'd17;
      5'd9:    f = 5'd19;
      5'd10:   f = 5'd20;
      5'd11:   f = 5'd21;
      5'd12:   f = 5'd22;
      5'd14:   f = 5'd23;
      5'd15:   f = 5'd24;
      5'd16:   f = 5'd25;
      5'd17:   f = 5'd26;
      5'd18:   f = 5'd27;
      default: f = NO_FINAL;
    endcase
    return f;
  endfunction

  // Final left after removing the second part of a compound
  function automatic logic [4:0] final_keep(input logic [4:0] f);
    logic [4:0] k;
    unique case (f)
      5'd3:    k = 5'd1;
      5'd5,
      5'd6:    k = 5'd4;
      5'd9, 5'd10, 5'd11, 5'd12,
      5'd13, 5'd14, 5'd15: k = 5'd8;
      5'd18:   k = 5'd17;
      default: k = NO_FINAL;
    endcase
    return k;
  endfunction

  // Initial that moves onto the next syllable when a vowel follows
  function automatic logic [4:0] final_moves(input logic [4:0] f);
    logic [4:0] m;
    unique case (f)
      5'd2:    m = 5'd1;
      5'd3:    m = 5'd9;
      5'd4:    m = 5'd2;
      5'd5:    m = 5'd12;
      5'd6:    m = 5'd18;
      5'd7:    m = 5'd3;
      5'd8:    m = 5'd5;
      5'd10:   m = 5'd6;
      5'd11:   m = 5'd7;
      5'd12:   m = 5'd9;
      5'd13:   m = 5'd16;
      5'd14:   m = 5'd17;
      5'd15:   m = 5'd18;
      5'd16:   m = 5'd6;
      5'd17:   m = 5'd7;
      5'd18:   m = 5'd9;
      5'd19:   m = 5'd9;
      5'd20:   m = 5'd10;
      5'd21:   m = 5'd11;
      5'd22:   m = 5'd12;
      5'd23:   m = 5'd14;
      5'd24:   m = 5'd15;
      5'd25:   m = 5'd16;
      5'd26:   m = 5'd17;
      5'd27:   m = 5'd18;
      default: m = 5'd0;
    endcase
    return m;
  endfunction

  // Compound final from a final and a consonant; zero when no compound exists
  function automatic logic [4:0] merge_final(input logic [4:0] f, input logic [4:0] c);
    logic [4:0] r;
    r = NO_FINAL;
    priority if (f == 5'd1 && c == 5'd9)  r = 5'd3;
    else if (f == 5'd4 && c == 5'd12)     r = 5'd5;
    else if (f == 5'd4 && c == 5'd18)     r = 5'd6;
    else if (f == 5'd8 && c == 5'd0)      r = 5'd9;
    else if (f == 5'd8 && c == 5'd6)      r = 5'd10;
    else if (f == 5'd8 && c == 5'd7)      r = 5'd11;
    else if (f == 5'd8 && c == 5'd9)      r = 5'd12;
    else if (f == 5'd8 && c == 5'd16)     r = 5'd13;
    else if (f == 5'd8 && c == 5'd17)     r = 5'd14;
    else if (f == 5'd8 && c == 5'd18)     r = 5'd15;
    else if (f == 5'd17 && c == 5'd9)     r = 5'd18;
    else                                  r = NO_FINAL;
    return r;
  endfunction

  // Compound vowel from a medial and a vowel
  function automatic hts_merge_t merge_medial(input logic [4:0] m, input logic [4:0] v);
    hts_merge_t r;
    r.hit  = 1'b1;
    r.jamo = 5'd0;
    priority if (m == 5'd8 && v == 5'd0)   r.jamo = 5'd9;
    else if (m == 5'd8 && v == 5'd1)       r.jamo = 5'd10;
    else if (m == 5'd8 && v == 5'd20)      r.jamo = 5'd11;
    else if (m == 5'd13 && v == 5'd4)      r.jamo = 5'd14;
    else if (m == 5'd13 && v == 5'd5)      r.jamo = 5'd15;
    else if (m == 5'd13 && v == 5'd20)     r.jamo = 5'd16;
    else if (m == 5'd18 && v == 5'd20)     r.jamo = 5'd19;
    else                                   r.hit  = 1'b0;
    return r;
  endfunction

  function automatic logic [15:0] syllable(input logic [4:0] i, input logic [4:0] m,
                                           input logic [4:0] f);
    return SYL_BASE + ({11'd0, i} * SYL_INIT_STEP) + ({11'd0, m} * SYL_MED_STEP)
           + {11'd0, f};
  endfunction

  // Code shown for a composition; zero when nothing is composed
  function automatic logic [15:0] preedit_code(input hts_comp_t s);
    logic [15:0] code;
    priority if (s.ini_present && s.med_present)
      code = syllable(s.ini_jamo, s.med_jamo, s.fin_jamo);
    else if (s.ini_present)
      code = initial_code(s.ini_jamo);
    else if (s.med_present)
      code = VOWEL_BASE + {11'd0, s.med_jamo};
    else
      code = 16'd0;
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hts_front.sv =====
// ----------------------------------------------------------------------------
// hts_front
// Accepts keys, runs the composition automaton and queues a result plan.
// ----------------------------------------------------------------------------
`default_nettype none

module hts_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              key_valid_i,
  output logic                   key_ready_o,
  input  wire logic [2:0]        key_mode_i,
  input  wire logic [4:0]        consonant_index_i,
  input  wire logic [4:0]        vowel_index_i,
  input  wire logic [7:0]        char_code_i,
  output logic                   push_o,
  output hts_pkg::hts_plan_t     plan_o,
  input  wire logic              q_full_i
);
  import hts_pkg::*;

  hts_comp_t  comp_q, comp_d;
  hts_comp_t  comp_nxt;
  hts_comp_t  cleared;
  hts_mode_e  mode;
  hts_merge_t med_merge;
  logic [4:0] fin_new;
  logic [15:0] pre_cur;
  logic [15:0] vowel_code;
  logic [15:0] other_code;

  assign key_ready_o = !q_full_i;
  assign push_o      = key_valid_i && !q_full_i;
  assign mode        = hts_mode_e'(key_mode_i);
  assign cleared     = '0;
  assign pre_cur     = preedit_code(comp_q);
  assign vowel_code  = VOWEL_BASE + {11'd0, vowel_index_i};
  assign med_merge   = merge_medial(comp_q.med_jamo, vowel_index_i);

  // Pick the final that the consonant would form
  always_comb begin
    if (comp_q.fin_jamo == NO_FINAL) begin
      fin_new = initial_to_final(consonant_index_i);
    end else begin
      fin_new = merge_final(comp_q.fin_jamo, consonant_index_i);
    end
  end

  // Raw code committed by space, newline and other keys
  always_comb begin
    unique case (mode)
      MODE_SPACE:   other_code = CODE_SPACE;
      MODE_NEWLINE: other_code = CODE_NEWLINE;
      default:      other_code = {8'd0, char_code_i};
    endcase
  end

  // Advance the automaton and build the plan: commits, erase flag and preedit
  always_comb begin
    comp_nxt       = comp_q;
    plan_o         = '0;
    unique case (mode)
      MODE_CONS: begin
        if (consonant_index_i < NUM_INITIALS) begin
          priority if (!comp_q.ini_present) begin
            comp_nxt.ini_present = 1'b1;
            comp_nxt.ini_jamo    = consonant_index_i;
          end else if (!comp_q.med_present) begin
            plan_o.n_commit   = 2'd1;
            plan_o.commit0    = initial_code(comp_q.ini_jamo);
            comp_nxt.ini_jamo = consonant_index_i;
          end else if (fin_new != NO_FINAL) begin
            comp_nxt.fin_jamo = fin_new;
          end else begin
            plan_o.n_commit      = 2'd1;
            plan_o.commit0       = pre_cur;
            comp_nxt             = cleared;
            comp_nxt.ini_present = 1'b1;
            comp_nxt.ini_jamo    = consonant_index_i;
          end
        end
      end
      MODE_VOWEL: begin
        if (vowel_index_i < NUM_VOWELS) begin
          priority if (comp_q.ini_present && !comp_q.med_present) begin
            comp_nxt.med_present = 1'b1;
            comp_nxt.med_jamo    = vowel_index_i;
          end else if (comp_q.ini_present && comp_q.fin_jamo == NO_FINAL) begin
            if (med_merge.hit) begin
              comp_nxt.med_jamo = med_merge.jamo;
            end else begin
              plan_o.n_commit = 2'd2;
              plan_o.commit0  = pre_cur;
              plan_o.commit1  = vowel_code;
              comp_nxt        = cleared;
            end
          end else if (comp_q.ini_present) begin
            // move the trailing consonant onto a new syllable
            plan_o.n_commit      = 2'd1;
            plan_o.commit0       = syllable(comp_q.ini_jamo, comp_q.med_jamo,
                                            final_keep(comp_q.fin_jamo));
            comp_nxt.ini_present = 1'b1;
            comp_nxt.ini_jamo    = final_moves(comp_q.fin_jamo);
            comp_nxt.med_present = 1'b1;
            comp_nxt.med_jamo    = vowel_index_i;
            comp_nxt.fin_jamo    = NO_FINAL;
          end else begin
            if (comp_q.med_present) begin
              plan_o.n_commit = 2'd2;
              plan_o.commit0  = pre_cur;
              plan_o.commit1  = vowel_code;
            end else begin
              plan_o.n_commit = 2'd1;
              plan_o.commit0  = vowel_code;
            end
            comp_nxt = cleared;
          end
        end
      end
      MODE_BKSP: begin
        priority if (comp_q.fin_jamo != NO_FINAL) begin
          comp_nxt.fin_jamo = final_keep(comp_q.fin_jamo);
        end else if (comp_q.med_present) begin
          priority if (comp_q.med_jamo >= 5'd9 && comp_q.med_jamo <= 5'd11) begin
            comp_nxt.med_jamo = 5'd8;
          end else if (comp_q.med_jamo >= 5'd14 && comp_q.med_jamo <= 5'd16) begin
            comp_nxt.med_jamo = 5'd13;
          end else if (comp_q.med_jamo == 5'd19) begin
            comp_nxt.med_jamo = 5'd18;
          end else begin
            comp_nxt.med_present = 1'b0;
            comp_nxt.med_jamo    = 5'd0;
          end
        end else if (comp_q.ini_present) begin
          comp_nxt.ini_present = 1'b0;
          comp_nxt.ini_jamo    = 5'd0;
        end else begin
          plan_o.erase = 1'b1;
        end
      end
      MODE_SPACE, MODE_NEWLINE, MODE_OTHER: begin
        if (comp_q.ini_present || comp_q.med_present) begin
          plan_o.n_commit = 2'd2;
          plan_o.commit0  = pre_cur;
          plan_o.commit1  = other_code;
        end else begin
          plan_o.n_commit = 2'd1;
          plan_o.commit0  = other_code;
        end
        comp_nxt = cleared;
      end
      default: begin
        comp_nxt = comp_q;
      end
    endcase
    plan_o.pre_valid = comp_nxt.ini_present || comp_nxt.med_present;
    plan_o.pre_char  = preedit_code(comp_nxt);
  end

  // Update the composition on each accepted beat
  assign comp_d = push_o ? comp_nxt : comp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_q <= '0;
    end else begin
      comp_q <= comp_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hts_queue.sv =====
// ----------------------------------------------------------------------------
// hts_queue
// Two-entry plan queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module hts_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire hts_pkg::hts_plan_t plan_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   head_valid_o,
  output hts_pkg::hts_plan_t     head_o
);
  import hts_pkg::*;

  localparam int unsigned Depth = 2;

  hts_plan_t  mem_q [Depth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o       = (count_q == 2'(Depth));
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the plan
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= plan_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hts_back.sv =====
// ----------------------------------------------------------------------------
// hts_back
// Walks one queued plan and sends its commit beats and its closing beat.
// ----------------------------------------------------------------------------
`default_nettype none

module hts_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              head_valid_i,
  input  wire hts_pkg::hts_plan_t head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   commit_valid_o,
  output logic [15:0]            commit_char_o,
  output logic                   erase_previous_o,
  output logic                   preedit_valid_o,
  output logic [15:0]            preedit_char_o,
  output logic                   last_o
);
  import hts_pkg::*;

  logic [1:0] step_q, step_d;
  logic       at_last;
  logic       fire;

  assign at_last     = (step_q == head_i.n_commit);
  assign out_valid_o = head_valid_i;
  assign fire        = head_valid_i && out_ready_i;
  assign pop_o       = fire && at_last;

  // Select the beat for the current step
  always_comb begin
    commit_valid_o   = !at_last;
    commit_char_o    = 16'd0;
    erase_previous_o = 1'b0;
    preedit_valid_o  = 1'b0;
    preedit_char_o   = 16'd0;
    last_o           = at_last;
    if (at_last) begin
      erase_previous_o = head_i.erase;
      preedit_valid_o  = head_i.pre_valid;
      preedit_char_o   = head_i.pre_char;
    end else if (step_q == 2'd0) begin
      commit_char_o = head_i.commit0;
    end else begin
      commit_char_o = head_i.commit1;
    end
  end

  // Advance the step on each sent beat, restart at the closing beat
  always_comb begin
    step_d = step_q;
    if (fire) begin
      step_d = at_last ? 2'd0 : step_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hangul_two_set_composer.sv =====
// ----------------------------------------------------------------------------
// hangul_two_set_composer
// Two-set Hangul composition: classified keys in, committed and preedit
// characters out.
//
// Keys arrive on the s_axis group; the key class rides on tuser. For each key
// the m_axis group sends zero to two commit beats (syllables, compatibility
// jamo, space, newline or the raw character) and then one beat with tlast set
// that carries the preedit and the erase flag.
// The front takes a key and updates the composition at once; a
// two-entry plan queue parts it from the back, which sends one beat a cycle
// while the receiver is ready. A key thus makes one to three beats; its plan
// is registered in the queue before its first beat is sent. With the queue full the
// front drops tready, so a stalled receiver holds keys back without loss.
// Reset clears the composition, the queue and the beat counter.
// ----------------------------------------------------------------------------
`default_nettype none

module hangul_two_set_composer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [4:0] consonant_index, [9:5] vowel_index, [17:10] char_code
  input  wire logic [23:0] s_axis_tdata,
  // [2:0] mode
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] commit_char, [31:16] preedit_char
  output logic [31:0]      m_axis_tdata,
  // [0] commit_valid, [1] erase_previous, [2] preedit_valid
  output logic [2:0]       m_axis_tuser,
  output logic             m_axis_tlast
);
  import hts_pkg::*;

  hts_plan_t   plan;
  hts_plan_t   head;
  logic        push;
  logic        q_full;
  logic        pop;
  logic        head_valid;
  logic        commit_valid;
  logic [15:0] commit_char;
  logic        erase_previous;
  logic        preedit_valid;
  logic [15:0] preedit_char;

  // Take classified keys and run the automaton
  hts_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .key_valid_i       (s_axis_tvalid),
    .key_ready_o       (s_axis_tready),
    .key_mode_i        (s_axis_tuser),
    .consonant_index_i (s_axis_tdata[4:0]),
    .vowel_index_i     (s_axis_tdata[9:5]),
    .char_code_i       (s_axis_tdata[17:10]),
    .push_o            (push),
    .plan_o            (plan),
    .q_full_i          (q_full)
  );

  // Hold plans between front and back
  hts_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .plan_i       (plan),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Send the beats of each plan
  hts_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .commit_valid_o   (commit_valid),
    .commit_char_o    (commit_char),
    .erase_previous_o (erase_previous),
    .preedit_valid_o  (preedit_valid),
    .preedit_char_o   (preedit_char),
    .last_o           (m_axis_tlast)
  );

  // Pack the output beat
  assign m_axis_tdata = {preedit_char, commit_char};
  assign m_axis_tuser = {preedit_valid, erase_previous, commit_valid};

endmodule

`default_nettype wire
